// ===== rtl/sed_pkg.sv =====
package sed_pkg;

    localparam int ACT_W  = 2;
    localparam int ELEM_W = 32;
    localparam int RES_W  = 8;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_FIRST   = 2'd0;
    localparam t_action ACT_SECOND  = 2'd1;
    localparam t_action ACT_COMPUTE = 2'd2;

    // search result handed from the sequencer to the output stage
    typedef struct packed {
        logic                    done;
        logic [RES_W-1:0]        edit_distance;
        logic signed [RES_W-1:0] end_diagonal;
    } t_sed_res;

endpackage

// ===== rtl/sed_ram.sv =====
module sed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sed_search.sv =====
module sed_search #(
    parameter int MAX_LEN  = 64,
    parameter int ID_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0] i_first_len,
    input  logic [$clog2(MAX_LEN+1)-1:0] i_second_len,
    output logic [$clog2(MAX_LEN)-1:0]   o_first_addr,
    output logic [$clog2(MAX_LEN)-1:0]   o_second_addr,
    input  logic [ID_WIDTH-1:0]          i_first_data,
    input  logic [ID_WIDTH-1:0]          i_second_data,
    output sed_pkg::t_sed_res            o_res
);
    import sed_pkg::*;

    localparam int ADDR_W     = $clog2(MAX_LEN);
    // reach x can run past the first length by up to d
    localparam int X_W        = $clog2(4 * MAX_LEN + 1);
    localparam int K_W        = X_W + 1;
    localparam int Y_W        = X_W + 2;
    localparam int DIAG_LIMIT = 2 * MAX_LEN;
    localparam int DIAG_OFF   = 2 * MAX_LEN + 1;
    localparam int SLOTS      = 4 * MAX_LEN + 3;
    localparam int RIDX_W     = $clog2(SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDL  = 3'd1;
    localparam logic [2:0] S_RDH  = 3'd2;
    localparam logic [2:0] S_SEL  = 3'd3;
    localparam logic [2:0] S_SNK  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [X_W-1:0]        r_d, n_d;
    logic signed [K_W-1:0] r_k, n_k;
    logic [X_W-1:0]        r_x, n_x;
    logic [X_W-1:0]        r_lo, n_lo;
    t_sed_res              r_res, n_res;

    logic signed [K_W-1:0] d_s;
    logic signed [Y_W-1:0] y_s;
    logic signed [Y_W-1:0] n_len_s;
    logic [X_W-1:0]        m_len_x;
    logic [X_W-1:0]        inc_in, inc_out;
    logic [X_W-1:0]        reach_rd;
    logic [RIDX_W-1:0]     rd_idx, wr_idx;
    logic signed [K_W:0]   rd_sum, wr_sum;
    logic                  in_box, at_end;
    logic signed [K_W+7:0] k_wide;
    logic [X_W+7:0]        d_wide;

    assign d_s     = signed'({1'b0, r_d});
    assign y_s     = signed'({2'b00, r_x}) - signed'({r_k[K_W-1], r_k});
    assign n_len_s = signed'(Y_W'(i_second_len));
    assign m_len_x = X_W'(i_first_len);

    assign in_box = (r_x < m_len_x) && (y_s >= 0) && (y_s < n_len_s);
    assign at_end = (r_x >= m_len_x) && (y_s >= n_len_s);

    // shared incrementer: x+1 from the lower diagonal, or one snake step
    assign inc_in  = (r_state == S_SEL) ? r_lo : r_x;
    assign inc_out = inc_in + X_W'(1);

    assign rd_sum = (r_state == S_RDL) ? ({r_k[K_W-1], r_k} + (K_W+1)'(DIAG_OFF - 1))
                                       : ({r_k[K_W-1], r_k} + (K_W+1)'(DIAG_OFF + 1));
    assign wr_sum = {r_k[K_W-1], r_k} + (K_W+1)'(DIAG_OFF);
    assign rd_idx = rd_sum[RIDX_W-1:0];
    assign wr_idx = wr_sum[RIDX_W-1:0];

    assign k_wide = {{8{r_k[K_W-1]}}, r_k};
    assign d_wide = {8'd0, r_d};

    sed_ram #(
        .WIDTH (X_W),
        .DEPTH (SLOTS)
    ) u_reach (
        .i_clk     (i_clk),
        .i_we      (r_state == S_WR),
        .i_wr_addr (wr_idx),
        .i_wr_data (r_x),
        .i_rd_addr (rd_idx),
        .o_rd_data (reach_rd)
    );

    assign o_first_addr  = r_x[ADDR_W-1:0];
    assign o_second_addr = y_s[ADDR_W-1:0];
    assign o_res         = r_res;

    always_comb begin
        n_state    = r_state;
        n_d        = r_d;
        n_k        = r_k;
        n_x        = r_x;
        n_lo       = r_lo;
        n_res      = r_res;
        n_res.done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_d     = '0;
                    n_k     = '0;
                    n_state = S_RDL;
                end
            end
            S_RDL: n_state = S_RDH;
            S_RDH: begin
                n_lo    = reach_rd;
                n_state = S_SEL;
            end
            S_SEL: begin
                // level zero starts at x = 0 on the main diagonal
                if (r_d == '0) begin
                    n_x = '0;
                end else if ((r_k == -d_s) || ((r_k != d_s) && (r_lo < reach_rd))) begin
                    n_x = reach_rd;
                end else begin
                    n_x = inc_out;
                end
                n_state = S_SNK;
            end
            S_SNK: n_state = in_box ? S_CMP : S_WR;
            S_CMP: begin
                if (i_first_data == i_second_data) begin
                    n_x     = inc_out;
                    n_state = S_SNK;
                end else begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                if (at_end) begin
                    n_res.done          = 1'b1;
                    n_res.edit_distance = d_wide[RES_W-1:0];
                    n_res.end_diagonal  = k_wide[RES_W-1:0];
                    n_state             = S_IDLE;
                end else if (r_k == d_s) begin
                    if (r_d == X_W'(DIAG_LIMIT)) begin
                        // search exhausted, reported as zero
                        n_res.done          = 1'b1;
                        n_res.edit_distance = '0;
                        n_res.end_diagonal  = '0;
                        n_state             = S_IDLE;
                    end else begin
                        n_d     = r_d + X_W'(1);
                        n_k     = -d_s - K_W'(1);
                        n_state = S_RDL;
                    end
                end else begin
                    n_k     = r_k + K_W'(2);
                    n_state = S_RDL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d  <= n_d;
        r_k  <= n_k;
        r_x  <= n_x;
        r_lo <= n_lo;
    end

endmodule

// ===== rtl/sequence_edit_distance.sv =====
// Operation: an append transaction is taken while idle; a compute transaction
//   visits each diagonal through the RDL, RDH, SEL, SNK and WR states, adds a
//   CMP and SNK step per matched snake element and a CMP when the snake stops
//   on a mismatch inside both sequences, then loads the result register.
// Throughput: one transaction at a time; the diagonal sequencer and the single
//   read port of its reach memory set the compute time.
// Reset: synchronous, active low; clears lengths, overflow flag and control.
module sequence_edit_distance #(
    parameter int MAX_LEN  = 64,
    parameter int ID_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sed_pkg::ELEM_W-1:0]    s_axis_tdata,  // [31:0] element_id
    input  logic [sed_pkg::ACT_W-1:0]     s_axis_tuser,  // [1:0] action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*sed_pkg::RES_W-1:0]   m_axis_tdata,  // [7:0] edit_distance,
                                                         // [15:8] end_diagonal
    output logic [0:0]                    m_axis_tuser   // [0] status
);
    import sed_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);

    // top-level control: taking transactions, waiting on the search,
    // holding the result until the sink takes it
    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_OUT  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [LEN_W-1:0]    r_first_len, n_first_len;
    logic [LEN_W-1:0]    r_second_len, n_second_len;
    logic                r_ovf, n_ovf;
    logic                r_status;
    logic [RES_W-1:0]    r_dist;
    logic [RES_W-1:0]    r_diag;

    logic                in_acc, out_acc;
    t_action             act;
    logic                first_full, second_full;
    logic                first_we, second_we, start;
    logic [ID_WIDTH-1:0] id_store;
    logic [ADDR_W-1:0]   first_rd_addr, second_rd_addr;
    logic [ID_WIDTH-1:0] first_rd_data, second_rd_data;
    t_sed_res            res;

    assign s_axis_tready = (r_state == T_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign act           = s_axis_tuser;

    // only the low ID_WIDTH bits are kept; a wider ID_WIDTH zero-extends the identifier
    generate
        if (ID_WIDTH <= ELEM_W) begin : g_id_trunc
            assign id_store = s_axis_tdata[ID_WIDTH-1:0];
        end else begin : g_id_ext
            assign id_store = {{(ID_WIDTH - ELEM_W){1'b0}}, s_axis_tdata};
        end
    endgenerate

    assign first_full  = (r_first_len == LEN_W'(MAX_LEN));
    assign second_full = (r_second_len == LEN_W'(MAX_LEN));
    assign first_we    = in_acc && (act == ACT_FIRST) && !first_full;
    assign second_we   = in_acc && (act == ACT_SECOND) && !second_full;
    assign start       = in_acc && (act == ACT_COMPUTE);

    sed_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_first_seq (
        .i_clk     (i_clk),
        .i_we      (first_we),
        .i_wr_addr (r_first_len[ADDR_W-1:0]),
        .i_wr_data (id_store),
        .i_rd_addr (first_rd_addr),
        .o_rd_data (first_rd_data)
    );

    sed_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (MAX_LEN)
    ) u_second_seq (
        .i_clk     (i_clk),
        .i_we      (second_we),
        .i_wr_addr (r_second_len[ADDR_W-1:0]),
        .i_wr_data (id_store),
        .i_rd_addr (second_rd_addr),
        .o_rd_data (second_rd_data)
    );

    // diagonal sequencer with the reach vector
    sed_search #(
        .MAX_LEN  (MAX_LEN),
        .ID_WIDTH (ID_WIDTH)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_first_len   (r_first_len),
        .i_second_len  (r_second_len),
        .o_first_addr  (first_rd_addr),
        .o_second_addr (second_rd_addr),
        .i_first_data  (first_rd_data),
        .i_second_data (second_rd_data),
        .o_res         (res)
    );

    always_comb begin
        n_state      = r_state;
        n_first_len  = r_first_len;
        n_second_len = r_second_len;
        n_ovf        = r_ovf;
        unique case (r_state)
            T_IDLE: begin
                if (in_acc) begin
                    case (act)
                        ACT_FIRST: begin
                            if (first_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_first_len = r_first_len + LEN_W'(1);
                            end
                        end
                        ACT_SECOND: begin
                            if (second_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_second_len = r_second_len + LEN_W'(1);
                            end
                        end
                        ACT_COMPUTE: n_state = T_BUSY;
                        default: ;  // unused action: dropped
                    endcase
                end
            end
            T_BUSY: begin
                if (res.done) begin
                    n_state = T_OUT;
                end
            end
            T_OUT: begin
                // result taken: both sequences and the sticky flag clear
                if (out_acc) begin
                    n_first_len  = '0;
                    n_second_len = '0;
                    n_ovf        = 1'b0;
                    n_state      = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_first_len  <= '0;
            r_second_len <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_len  <= n_first_len;
            r_second_len <= n_second_len;
            r_ovf        <= n_ovf;
        end
    end

    // result register, loaded when the search finishes
    always_ff @(posedge i_clk) begin
        if (res.done) begin
            r_dist   <= res.edit_distance;
            r_diag   <= res.end_diagonal;
            r_status <= r_ovf;
        end
    end

    assign m_axis_tvalid = (r_state == T_OUT);
    assign m_axis_tdata  = {r_diag, r_dist};
    assign m_axis_tuser  = r_status;

endmodule

// ===== rtl/sed_checker.sv =====
module sed_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [sed_pkg::ELEM_W-1:0]  s_axis_tdata,
    input logic [sed_pkg::ACT_W-1:0]   s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [2*sed_pkg::RES_W-1:0] m_axis_tdata,
    input logic [0:0]                  m_axis_tuser
);
    import sed_pkg::*;

    // a held result keeps its payload until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // input side is closed whenever a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while result pending");

    // a compute transaction makes the block busy
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_COMPUTE) |=>
            !s_axis_tready)
        else $error("still ready after compute");

    // taking the result reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
        else $error("not idle after result taken");

    // append and unused-action transactions never yield a result
    a_append_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != ACT_COMPUTE) |=>
            s_axis_tready && !m_axis_tvalid)
        else $error("append produced a result");

endmodule

bind sequence_edit_distance sed_checker u_sed_checker (.*);
